### rtl/imup_pkg.sv
// ----------------------------------------------------------------------------
// imup_pkg: shared types and constants for the IMU packet converter
// Holds widths, header codes, scale factors, the sequencer encodings, the
// handshake structs between the units and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package imup_pkg;

    // Sine table resolution: 2^SINE_ADDR_BITS steps over a quarter turn.
    localparam int SINE_ADDR_BITS = 10;
    localparam int TAB_N          = 1 << SINE_ADDR_BITS;
    localparam int ROM_AW         = SINE_ADDR_BITS + 1;
    localparam int IDX_SH         = 15 - SINE_ADDR_BITS;
    localparam int IDX_RND        = 1 << (14 - SINE_ADDR_BITS);

    // Notification framing.
    localparam logic [7:0] HDR0       = 8'h55;
    localparam logic [7:0] HDR1       = 8'h61;
    localparam logic [4:0] MIN_LEN    = 5'd20;
    localparam int         STORE_LEN  = 18;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int ACC_W   = 25;
    localparam int RATE_W  = 23;
    localparam int QUAT_W  = 17;
    localparam int OUT_W   = 216;
    localparam int TVAL_W  = 16;

    // Scale factors.
    localparam logic [39:0] ACC_NUM  = 40'd3138128;
    localparam logic [36:0] ACC_HALF = 37'd5000;
    localparam logic [39:0] RATE_K   = 40'd299845282323;

    // Shift-add multiplier.
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_C_W = 5;

    // Restoring divider by a fixed divisor.
    localparam int          DIV_N_W = 37;
    localparam int          DIV_Q_W = 24;
    localparam int          DIV_R_W = 15;
    localparam int          DIV_C_W = 6;
    localparam logic [14:0] DIV_D   = 15'd10000;

    // Quaternion accumulation.
    localparam int PAIR_W = 31;
    localparam int TRIP_W = 46;
    localparam int QACC_W = 48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_ROM,
        ST_QUAT,
        ST_FIN
    } state_t;

    // One entry per multiply in the conversion, in issue order, then an end marker.
    typedef enum logic [4:0] {
        JOB_ACC_X,
        JOB_ACC_Y,
        JOB_ACC_Z,
        JOB_RATE_X,
        JOB_RATE_Y,
        JOB_RATE_Z,
        JOB_CRCP,
        JOB_SRSP,
        JOB_SRCP,
        JOB_CRSP,
        JOB_CCC,
        JOB_SSS,
        JOB_SCC,
        JOB_CSS,
        JOB_CSC,
        JOB_SCS,
        JOB_CCS,
        JOB_SSC,
        JOB_END
    } job_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    typedef logic [TVAL_W-1:0] sine_tab_t [0:TAB_N];

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // (a*b) >> 62 for Q62 operands.
    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(32768*sin(x)) for x in [0, pi/2] given in Q62, by Taylor series.
    function automatic logic [TVAL_W-1:0] sine_q15(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < 29; n += 2) begin
            term = mul_q62(term, x2) / 64'((n + 1) * (n + 2));
            if ((((n + 1) / 2) & 1) != 0) begin
                sum = sum - term;
            end
            else begin
                sum = sum + term;
            end
        end
        rnd = (sum + (64'd1 << 46)) >> 47;
        return rnd[TVAL_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] kk;
        q = HALF_PI_Q62 >> SINE_ADDR_BITS;
        r = HALF_PI_Q62 & 64'(TAB_N - 1);
        for (int k = 0; k <= TAB_N; k++) begin
            kk   = 64'(k);
            t[k] = sine_q15(q * kk + ((r * kk) >> SINE_ADDR_BITS));
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

### rtl/imup_sine_rom.sv
// ----------------------------------------------------------------------------
// imup_sine_rom: quarter-wave sine table
// Constant table with a registered read port, one lookup per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imup_sine_rom (
    input  wire logic                         clk,
    input  wire logic [imup_pkg::ROM_AW-1:0]  addr,
    output logic      [imup_pkg::TVAL_W-1:0]  data
);

    logic [imup_pkg::TVAL_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= imup_pkg::SINE_TAB[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### rtl/imup_serial_mul.sv
// ----------------------------------------------------------------------------
// imup_serial_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle, least significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module imup_serial_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire imup_pkg::mul_req_t req,
    output imup_pkg::mul_rsp_t      rsp
);

    logic [imup_pkg::MUL_A_W-1:0] a_reg;
    logic [imup_pkg::MUL_B_W-1:0] b_reg;
    logic [imup_pkg::MUL_P_W-1:0] acc_reg;
    logic [imup_pkg::MUL_P_W-1:0] acc_next;
    logic [imup_pkg::MUL_A_W:0]   part_sum;
    logic [imup_pkg::MUL_C_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    // The upper bits take the partial product, then everything moves right.
    always_comb
    begin
        part_sum = {1'b0, acc_reg[imup_pkg::MUL_P_W-1:imup_pkg::MUL_B_W]}
                 + (b_reg[0] ? {1'b0, a_reg} : '0);
        acc_next = {part_sum, acc_reg[imup_pkg::MUL_B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= imup_pkg::MUL_C_W'(imup_pkg::MUL_B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == imup_pkg::MUL_C_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg >> 1;
            acc_reg <= acc_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire

### rtl/imup_const_div.sv
// ----------------------------------------------------------------------------
// imup_const_div: restoring divider by the fixed acceleration divisor
// Produces one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module imup_const_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire imup_pkg::div_req_t req,
    output imup_pkg::div_rsp_t      rsp
);

    logic [imup_pkg::DIV_N_W-1:0] num_reg;
    logic [imup_pkg::DIV_R_W-1:0] rem_reg;
    logic [imup_pkg::DIV_Q_W-1:0] quo_reg;
    logic [imup_pkg::DIV_R_W-1:0] trial;
    logic [imup_pkg::DIV_R_W-1:0] rem_next;
    logic                         fits;
    logic [imup_pkg::DIV_C_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    always_comb
    begin
        trial    = {rem_reg[imup_pkg::DIV_R_W-2:0], num_reg[imup_pkg::DIV_N_W-1]};
        fits     = (trial >= imup_pkg::DIV_D);
        rem_next = fits ? (trial - imup_pkg::DIV_D) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= imup_pkg::DIV_C_W'(imup_pkg::DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == imup_pkg::DIV_C_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[imup_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/imu_packet_to_quaternion.sv
// ----------------------------------------------------------------------------
// imu_packet_to_quaternion: sensor notification to scaled IMU sample
// Parses a byte stream, scales acceleration and rate, builds a ZYX quaternion.
// ----------------------------------------------------------------------------
// Notification bytes enter on the slave stream, one transaction per byte, with
// tlast on the final byte. A notification of at least 20 bytes whose first two
// bytes are 0x55 and 0x61 yields one master transaction; any other yields none.
// Bytes are taken at one per cycle while the block is idle. After the last
// byte of a good notification the input stalls for the conversion and then
// until the output register is free. One shared bit-serial multiplier does all
// 18 multiplies (each a start, 16 bit steps and a done): three for accel, each
// followed by a division in a bit-serial divider, three for rate and, after the
// sine table reads, twelve for the quaternion, rounded before the output register
// is loaded. A finished result sits in the output register, so the next
// notification streams in while that result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_packet_to_quaternion (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] packet_byte
    input  wire logic                         s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // From bit 0 up: accel_x, accel_y, accel_z (25 bits each), rate_x, rate_y,
    // rate_z (23 bits each), quat_w, quat_x, quat_y, quat_z (17 bits each),
    // then four zero bits.
    output logic [imup_pkg::OUT_W-1:0]        m_tdata
);

    // Sequencer.
    imup_pkg::state_t state_reg;
    imup_pkg::state_t state_next;
    imup_pkg::job_t   job_reg;
    logic [2:0]       rc_reg;

    // Framing.
    logic [4:0] byte_count_reg;
    logic       hdr_ok_reg;
    logic [imup_pkg::BYTE_W-1:0] store_reg [0:imup_pkg::STORE_LEN-1];

    // Half-angle sines and cosines, magnitudes plus sine signs.
    logic [imup_pkg::TVAL_W-1:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    logic                        sr_neg_reg, sp_neg_reg, sy_neg_reg;

    logic [imup_pkg::PAIR_W-1:0] pair_cc_reg, pair_ss_reg, pair_sc_reg, pair_cs_reg;
    logic signed [imup_pkg::QACC_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    // Working results and the output register.
    logic [imup_pkg::ACC_W-1:0]  res_ax_reg, res_ay_reg, res_az_reg;
    logic [imup_pkg::RATE_W-1:0] res_rx_reg, res_ry_reg, res_rz_reg;
    logic [imup_pkg::QUAT_W-1:0] res_qw_reg, res_qx_reg, res_qy_reg, res_qz_reg;
    logic [imup_pkg::OUT_W-1:0]  out_reg;
    logic                        m_valid_reg;

    // Handshake and framing terms.
    logic       in_acc;
    logic       hdr_bad;
    logic [4:0] count_sat;
    logic       payload_in;
    logic       frame_ok;

    // Datapath terms.
    logic [imup_pkg::WORD_W-1:0] head_word;
    logic                        head_neg;
    logic [imup_pkg::WORD_W-1:0] head_mag;
    logic [imup_pkg::WORD_W:0]   idx_sum;
    logic [imup_pkg::WORD_W:0]   idx_raw;
    logic [imup_pkg::ROM_AW-1:0] idx;
    logic [imup_pkg::ROM_AW-1:0] rom_addr;
    logic [imup_pkg::TVAL_W-1:0] rom_data;

    imup_pkg::mul_req_t mul_req;
    imup_pkg::mul_rsp_t mul_rsp;
    imup_pkg::div_req_t div_req;
    imup_pkg::div_rsp_t div_rsp;

    logic [imup_pkg::MUL_A_W-1:0] mul_a;
    logic [imup_pkg::MUL_B_W-1:0] mul_b;
    logic                         term_neg;
    logic signed [imup_pkg::QACC_W-1:0] term;
    logic [imup_pkg::ACC_W-1:0]   acc_val;
    logic [54:0]                  rate_sum;
    logic [imup_pkg::RATE_W-1:0]  rate_val;
    logic [imup_pkg::OUT_W-1:0]   out_pack;

    // Control outputs of the sequencer.
    logic mul_start;
    logic div_start;
    logic store_adv;
    logic load_out;

    // Rounds a Q.45 sum half away from zero to Q.15 and clamps it to +-1.0.
    function automatic logic [imup_pkg::QUAT_W-1:0] quat_round(
        logic signed [imup_pkg::QACC_W-1:0] v);
        logic [imup_pkg::QACC_W-1:0] mag;
        logic [imup_pkg::QACC_W-1:0] rnd;
        logic [17:0]                 r;
        logic [imup_pkg::QUAT_W-1:0] sat;
        mag = v[imup_pkg::QACC_W-1] ? (~v + 1'b1) : v;
        rnd = mag + (imup_pkg::QACC_W'(1) << 29);
        r   = rnd[47:30];
        sat = (r > 18'd32768) ? 17'd32768 : r[16:0];
        return v[imup_pkg::QACC_W-1] ? (~sat + 1'b1) : sat;
    endfunction

    // ------------------------------------------------------------------
    // Framing: header check, byte count and payload capture.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == imup_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    always_comb
    begin
        hdr_bad    = ((byte_count_reg == 5'd0) && (s_tdata != imup_pkg::HDR0))
                  || ((byte_count_reg == 5'd1) && (s_tdata != imup_pkg::HDR1));
        count_sat  = (byte_count_reg < imup_pkg::MIN_LEN) ? (byte_count_reg + 5'd1)
                                                          : byte_count_reg;
        payload_in = in_acc && (byte_count_reg >= 5'd2)
                  && (byte_count_reg < imup_pkg::MIN_LEN);
        frame_ok   = in_acc && s_tlast && (count_sat == imup_pkg::MIN_LEN)
                  && hdr_ok_reg && !hdr_bad;
    end

    // ------------------------------------------------------------------
    // The payload store is a byte shift line. Once a notification is in,
    // the head always holds the next word to convert; each finished word
    // moves the line on by two bytes.
    // ------------------------------------------------------------------
    always_comb
    begin
        head_word = {store_reg[1], store_reg[0]};
        head_neg  = head_word[imup_pkg::WORD_W-1];
        head_mag  = head_neg ? (~head_word + 1'b1) : head_word;
        idx_sum   = {1'b0, head_mag} + (imup_pkg::WORD_W+1)'(imup_pkg::IDX_RND);
        idx_raw   = idx_sum >> imup_pkg::IDX_SH;
        idx       = (idx_raw > (imup_pkg::WORD_W+1)'(imup_pkg::TAB_N))
                  ? imup_pkg::ROM_AW'(imup_pkg::TAB_N)
                  : idx_raw[imup_pkg::ROM_AW-1:0];
        // Even steps read the sine, odd steps the cosine of the same angle.
        rom_addr  = rc_reg[0] ? (imup_pkg::ROM_AW'(imup_pkg::TAB_N) - idx) : idx;
    end

    // ------------------------------------------------------------------
    // Multiplier operand selection and the signed quaternion term.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        term_neg = 1'b0;
        case (job_reg)
            imup_pkg::JOB_ACC_X, imup_pkg::JOB_ACC_Y, imup_pkg::JOB_ACC_Z:
            begin
                mul_a = imup_pkg::ACC_NUM;
                mul_b = head_mag;
            end
            imup_pkg::JOB_RATE_X, imup_pkg::JOB_RATE_Y, imup_pkg::JOB_RATE_Z:
            begin
                mul_a = imup_pkg::RATE_K;
                mul_b = head_mag;
            end
            imup_pkg::JOB_CRCP:
            begin
                mul_a = imup_pkg::MUL_A_W'(cr_reg);
                mul_b = cp_reg;
            end
            imup_pkg::JOB_SRSP:
            begin
                mul_a = imup_pkg::MUL_A_W'(sr_reg);
                mul_b = sp_reg;
            end
            imup_pkg::JOB_SRCP:
            begin
                mul_a = imup_pkg::MUL_A_W'(sr_reg);
                mul_b = cp_reg;
            end
            imup_pkg::JOB_CRSP:
            begin
                mul_a = imup_pkg::MUL_A_W'(cr_reg);
                mul_b = sp_reg;
            end
            imup_pkg::JOB_CCC:
            begin
                mul_a = imup_pkg::MUL_A_W'(pair_cc_reg);
                mul_b = cy_reg;
            end
            imup_pkg::JOB_SSS:
            begin
                mul_a    = imup_pkg::MUL_A_W'(pair_ss_reg);
                mul_b    = sy_reg;
                term_neg = sr_neg_reg ^ sp_neg_reg ^ sy_neg_reg;
            end
            imup_pkg::JOB_SCC:
            begin
                mul_a    = imup_pkg::MUL_A_W'(pair_sc_reg);
                mul_b    = cy_reg;
                term_neg = sr_neg_reg;
            end
            imup_pkg::JOB_CSS:
            begin
                // Subtracted term of x.
                mul_a    = imup_pkg::MUL_A_W'(pair_cs_reg);
                mul_b    = sy_reg;
                term_neg = ~(sp_neg_reg ^ sy_neg_reg);
            end
            imup_pkg::JOB_CSC:
            begin
                mul_a    = imup_pkg::MUL_A_W'(pair_cs_reg);
                mul_b    = cy_reg;
                term_neg = sp_neg_reg;
            end
            imup_pkg::JOB_SCS:
            begin
                mul_a    = imup_pkg::MUL_A_W'(pair_sc_reg);
                mul_b    = sy_reg;
                term_neg = sr_neg_reg ^ sy_neg_reg;
            end
            imup_pkg::JOB_CCS:
            begin
                mul_a    = imup_pkg::MUL_A_W'(pair_cc_reg);
                mul_b    = sy_reg;
                term_neg = sy_neg_reg;
            end
            imup_pkg::JOB_SSC:
            begin
                // Subtracted term of z.
                mul_a    = imup_pkg::MUL_A_W'(pair_ss_reg);
                mul_b    = cy_reg;
                term_neg = ~(sr_neg_reg ^ sp_neg_reg);
            end
            default:
            begin
                mul_a    = '0;
                mul_b    = '0;
                term_neg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        term = term_neg
             ? -$signed({2'b00, mul_rsp.product[imup_pkg::TRIP_W-1:0]})
             :  $signed({2'b00, mul_rsp.product[imup_pkg::TRIP_W-1:0]});
        acc_val  = head_neg ? (~{1'b0, div_rsp.quo} + 1'b1) : {1'b0, div_rsp.quo};
        rate_sum = {1'b0, mul_rsp.product[53:0]} + (55'd1 << 31);
        rate_val = head_neg ? (~{1'b0, rate_sum[53:32]} + 1'b1)
                            : {1'b0, rate_sum[53:32]};
        out_pack = {4'd0, res_qz_reg, res_qy_reg, res_qx_reg, res_qw_reg,
                    res_rz_reg, res_ry_reg, res_rx_reg,
                    res_az_reg, res_ay_reg, res_ax_reg};
    end

    assign mul_req.start = mul_start;
    assign mul_req.a     = mul_a;
    assign mul_req.b     = mul_b;
    assign div_req.start = div_start;
    assign div_req.num   = mul_rsp.product[imup_pkg::DIV_N_W-1:0] + imup_pkg::ACC_HALF;

    imup_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    imup_const_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    imup_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imup_pkg::ST_IDLE:
            begin
                if (frame_ok)
                begin
                    state_next = imup_pkg::ST_MUL;
                end
            end
            imup_pkg::ST_MUL:
            begin
                state_next = imup_pkg::ST_MUL_WAIT;
            end
            imup_pkg::ST_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (job_reg <= imup_pkg::JOB_ACC_Z)
                    begin
                        state_next = imup_pkg::ST_DIV;
                    end
                    else if (job_reg == imup_pkg::JOB_RATE_Z)
                    begin
                        state_next = imup_pkg::ST_ROM;
                    end
                    else if (job_reg == imup_pkg::JOB_SSC)
                    begin
                        state_next = imup_pkg::ST_QUAT;
                    end
                    else
                    begin
                        state_next = imup_pkg::ST_MUL;
                    end
                end
            end
            imup_pkg::ST_DIV:
            begin
                state_next = imup_pkg::ST_DIV_WAIT;
            end
            imup_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = imup_pkg::ST_MUL;
                end
            end
            imup_pkg::ST_ROM:
            begin
                if (rc_reg == 3'd6)
                begin
                    state_next = imup_pkg::ST_MUL;
                end
            end
            imup_pkg::ST_QUAT:
            begin
                state_next = imup_pkg::ST_FIN;
            end
            imup_pkg::ST_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = imup_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imup_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        store_adv = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            imup_pkg::ST_MUL:
            begin
                mul_start = 1'b1;
            end
            imup_pkg::ST_MUL_WAIT:
            begin
                store_adv = mul_rsp.done && (job_reg >= imup_pkg::JOB_RATE_X)
                         && (job_reg <= imup_pkg::JOB_RATE_Z);
            end
            imup_pkg::ST_DIV:
            begin
                div_start = 1'b1;
            end
            imup_pkg::ST_DIV_WAIT:
            begin
                store_adv = div_rsp.done;
            end
            imup_pkg::ST_ROM:
            begin
                store_adv = rc_reg[0] && (rc_reg < 3'd6);
            end
            imup_pkg::ST_FIN:
            begin
                load_out = !m_valid_reg || m_tready;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= imup_pkg::ST_IDLE;
            job_reg        <= imup_pkg::JOB_ACC_X;
            rc_reg         <= '0;
            byte_count_reg <= '0;
            hdr_ok_reg     <= 1'b1;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc)
            begin
                if (s_tlast)
                begin
                    byte_count_reg <= '0;
                    hdr_ok_reg     <= 1'b1;
                end
                else
                begin
                    byte_count_reg <= count_sat;
                    if (hdr_bad)
                    begin
                        hdr_ok_reg <= 1'b0;
                    end
                end
            end

            if (frame_ok)
            begin
                job_reg <= imup_pkg::JOB_ACC_X;
            end
            else if ((state_reg == imup_pkg::ST_DIV_WAIT && div_rsp.done)
                  || (state_reg == imup_pkg::ST_MUL_WAIT && mul_rsp.done
                      && job_reg > imup_pkg::JOB_ACC_Z))
            begin
                job_reg <= imup_pkg::job_t'(job_reg + 5'd1);
            end

            if (state_reg == imup_pkg::ST_ROM)
            begin
                rc_reg <= rc_reg + 3'd1;
            end
            else
            begin
                rc_reg <= '0;
            end

            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (payload_in)
        begin
            for (int i = 0; i < imup_pkg::STORE_LEN - 1; i++)
            begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[imup_pkg::STORE_LEN-1] <= s_tdata;
        end
        else if (store_adv)
        begin
            for (int i = 0; i < imup_pkg::STORE_LEN - 2; i++)
            begin
                store_reg[i] <= store_reg[i+2];
            end
        end

        if (state_reg == imup_pkg::ST_ROM)
        begin
            case (rc_reg)
                3'd0: sr_neg_reg <= head_neg;
                3'd1: sr_reg     <= rom_data;
                3'd2:
                begin
                    cr_reg     <= rom_data;
                    sp_neg_reg <= head_neg;
                end
                3'd3: sp_reg     <= rom_data;
                3'd4:
                begin
                    cp_reg     <= rom_data;
                    sy_neg_reg <= head_neg;
                end
                3'd5: sy_reg     <= rom_data;
                3'd6: cy_reg     <= rom_data;
                default: cy_reg  <= cy_reg;
            endcase
        end

        if (frame_ok)
        begin
            qw_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end

        if (state_reg == imup_pkg::ST_DIV_WAIT && div_rsp.done)
        begin
            case (job_reg)
                imup_pkg::JOB_ACC_X: res_ax_reg <= acc_val;
                imup_pkg::JOB_ACC_Y: res_ay_reg <= acc_val;
                imup_pkg::JOB_ACC_Z: res_az_reg <= acc_val;
                default:             res_ax_reg <= res_ax_reg;
            endcase
        end

        if (state_reg == imup_pkg::ST_MUL_WAIT && mul_rsp.done)
        begin
            case (job_reg)
                imup_pkg::JOB_RATE_X: res_rx_reg  <= rate_val;
                imup_pkg::JOB_RATE_Y: res_ry_reg  <= rate_val;
                imup_pkg::JOB_RATE_Z: res_rz_reg  <= rate_val;
                imup_pkg::JOB_CRCP:   pair_cc_reg <= mul_rsp.product[imup_pkg::PAIR_W-1:0];
                imup_pkg::JOB_SRSP:   pair_ss_reg <= mul_rsp.product[imup_pkg::PAIR_W-1:0];
                imup_pkg::JOB_SRCP:   pair_sc_reg <= mul_rsp.product[imup_pkg::PAIR_W-1:0];
                imup_pkg::JOB_CRSP:   pair_cs_reg <= mul_rsp.product[imup_pkg::PAIR_W-1:0];
                imup_pkg::JOB_CCC,
                imup_pkg::JOB_SSS:    qw_reg      <= qw_reg + term;
                imup_pkg::JOB_SCC,
                imup_pkg::JOB_CSS:    qx_reg      <= qx_reg + term;
                imup_pkg::JOB_CSC,
                imup_pkg::JOB_SCS:    qy_reg      <= qy_reg + term;
                imup_pkg::JOB_CCS,
                imup_pkg::JOB_SSC:    qz_reg      <= qz_reg + term;
                default:              qw_reg      <= qw_reg;
            endcase
        end

        if (state_reg == imup_pkg::ST_QUAT)
        begin
            res_qw_reg <= quat_round(qw_reg);
            res_qx_reg <= quat_round(qx_reg);
            res_qy_reg <= quat_round(qy_reg);
            res_qz_reg <= quat_round(qz_reg);
        end

        if (load_out)
        begin
            out_reg <= out_pack;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == imup_pkg::ST_MUL_WAIT))
        else $error("multiplier finished outside its wait state");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == imup_pkg::ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= imup_pkg::MIN_LEN)
        else $error("byte count ran past the header plus payload length");

    a_all_jobs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == imup_pkg::ST_QUAT) |-> (job_reg == imup_pkg::JOB_END))
        else $error("quaternion rounding started before all products were summed");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

### tb/imu_sample_checker.sv
// ----------------------------------------------------------------------------
// imu_sample_checker: scoreboard for the IMU packet converter
// Watches the byte stream and the sample stream, predicts each sample from
// the accepted bytes and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    input  wire logic                      s_tready,
    input  wire logic [7:0]                s_tdata,
    input  wire logic                      s_tlast,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [imup_pkg::OUT_W-1:0] m_tdata,
    output int                             error_count,
    output int                             samples_pending
);
    import imup_pkg::*;

    typedef struct {
        logic signed [ACC_W-1:0]  acc [3];
        logic signed [RATE_W-1:0] rate [3];
        logic signed [QUAT_W-1:0] quat [4];
    } imu_sample_t;

    localparam sine_tab_t SINE_REF = build_sine_tab();

    imu_sample_t expected_samples [$];
    int          bytes_seen;
    logic        header_ok;
    logic [7:0]  payload [STORE_LEN];

    assign samples_pending = expected_samples.size();

    function automatic longint payload_word(int i);
        logic signed [15:0] w;
        w = {payload[2*i+1], payload[2*i]};
        return longint'(w);
    endfunction

    function automatic longint signed_mag(longint ref_v, longint m);
        return (ref_v < 0) ? -m : m;
    endfunction

    function automatic void half_angle_trig(longint a, output longint s, output longint c);
        longint m;
        longint idx;
        m   = (a < 0) ? -a : a;
        idx = (m + IDX_RND) >>> IDX_SH;
        if (idx > TAB_N)
        begin
            idx = TAB_N;
        end
        s = signed_mag(a, longint'(SINE_REF[idx]));
        c = longint'(SINE_REF[TAB_N - idx]);
    endfunction

    function automatic logic signed [QUAT_W-1:0] quat_round(longint v);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = signed_mag(v, (m + (64'd1 << 29)) >>> 30);
        if (r > 32768)
        begin
            r = 32768;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[QUAT_W-1:0];
    endfunction

    // Converts the stored payload of a good notification into a sample.
    function automatic imu_sample_t convert_payload();
        imu_sample_t r;
        longint      w;
        longint      m;
        logic [79:0] p;
        longint      sr, cr, sp, cp, sy, cy;
        for (int i = 0; i < 3; i++)
        begin
            w = payload_word(i);
            m = (w < 0) ? -w : w;
            r.acc[i] = ACC_W'(signed_mag(w, (m * 3138128 + 5000) / 10000));
        end
        for (int i = 0; i < 3; i++)
        begin
            w = payload_word(i + 3);
            m = (w < 0) ? -w : w;
            p = 80'(m) * 80'(RATE_K) + (80'd1 << 31);
            r.rate[i] = RATE_W'(signed_mag(w, longint'(p >> 32)));
        end
        half_angle_trig(payload_word(6), sr, cr);
        half_angle_trig(payload_word(7), sp, cp);
        half_angle_trig(payload_word(8), sy, cy);
        r.quat[0] = quat_round(cr * cp * cy + sr * sp * sy);
        r.quat[1] = quat_round(sr * cp * cy - cr * sp * sy);
        r.quat[2] = quat_round(cr * sp * cy + sr * cp * sy);
        r.quat[3] = quat_round(cr * cp * sy - sr * sp * cy);
        return r;
    endfunction

    function automatic void compare_field(string name, int idx, longint e, longint a);
        if (e != a)
        begin
            error_count++;
            $display("%0t: %s[%0d] mismatch, expected %0d, actual %0d",
                     $time, name, idx, e, a);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        imu_sample_t e;
        imu_sample_t got;
        if (!rst_n)
        begin
            bytes_seen  = 0;
            header_ok   = 1'b1;
            error_count = 0;
            expected_samples.delete();
        end
        else
        begin
            // Input side: track framing and store payload bytes.
            if (s_tvalid && s_tready)
            begin
                if (bytes_seen == 0)
                begin
                    if (s_tdata != HDR0) header_ok = 1'b0;
                end
                else if (bytes_seen == 1)
                begin
                    if (s_tdata != HDR1) header_ok = 1'b0;
                end
                else if (bytes_seen < MIN_LEN)
                begin
                    payload[bytes_seen - 2] = s_tdata;
                end
                if (bytes_seen < MIN_LEN) bytes_seen++;
                if (s_tlast)
                begin
                    if (bytes_seen >= MIN_LEN && header_ok)
                        expected_samples = {expected_samples, convert_payload()};
                    bytes_seen = 0;
                    header_ok  = 1'b1;
                end
            end
            // Output side: one sample per transaction.
            if (m_tvalid && m_tready)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    got.acc[i]  = m_tdata[i*ACC_W +: ACC_W];
                    got.rate[i] = m_tdata[3*ACC_W + i*RATE_W +: RATE_W];
                end
                for (int i = 0; i < 4; i++)
                    got.quat[i] = m_tdata[3*ACC_W + 3*RATE_W + i*QUAT_W +: QUAT_W];
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected sample, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    e = expected_samples.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        compare_field("accel", i, e.acc[i], got.acc[i]);
                        compare_field("rate", i, e.rate[i], got.rate[i]);
                    end
                    for (int i = 0; i < 4; i++)
                        compare_field("quat", i, e.quat[i], got.quat[i]);
                    if (m_tdata[OUT_W-1 -: 4] != 4'd0)
                        compare_field("pad", 0, 0, m_tdata[OUT_W-1 -: 4]);
                end
            end
        end
    end

endmodule

`default_nettype wire

### tb/tb_imu_packet_to_quaternion.sv
// ----------------------------------------------------------------------------
// tb_imu_packet_to_quaternion: testbench top for the IMU packet converter
// Sends directed and random notifications with random gaps, stalls the
// sample side at random and once for a long stretch, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_imu_packet_to_quaternion;
    import imup_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] packet_byte
    logic                 s_tlast;    // last_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;    // accel x/y/z, rate x/y/z, quat w/x/y/z, pad
    int                   error_count;
    int                   samples_pending;
    int                   bytes_sent;
    int                   idle_cycles;
    logic                 long_hold;
    logic                 stimulus_done;

    imu_packet_to_quaternion dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    imu_sample_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .samples_pending (samples_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sends one byte as a transaction after a random gap. Valid stays high
    // straight into the next byte when the gap is zero.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Sends a notification: header bytes, then the nine words, then extra
    // bytes; total length len, last flag on the final byte.
    task automatic send_notification(logic [7:0] h0, logic [7:0] h1,
                                     logic [15:0] words [9], int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0) b = h0;
            else if (i == 1) b = h1;
            else if (i < 20) b = (i % 2 == 0) ? words[(i-2)/2][7:0] : words[(i-2)/2][15:8];
            else b = 8'($urandom);
            send_byte(b, i == len - 1);
        end
    endtask

    // Random notification: mostly well formed, some short, long or bad.
    task automatic send_random_notification();
        logic [15:0] w [9];
        int          kind;
        int          len;
        logic [7:0]  h0;
        logic [7:0]  h1;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
        begin
            case ($urandom_range(0, 5))
                0: w[i] = 16'h8000;
                1: w[i] = 16'h7FFF;
                2: w[i] = 16'($urandom_range(0, 64)) - 16'd32;
                default: w[i] = 16'($urandom);
            endcase
        end
        h0  = HDR0;
        h1  = HDR1;
        len = 20;
        if (kind == 7) len = $urandom_range(1, 19);
        if (kind == 8) len = $urandom_range(21, 26);
        if (kind == 9)
        begin
            if ($urandom_range(0, 1)) h0 = 8'($urandom);
            else h1 = 8'($urandom);
        end
        send_notification(h0, h1, w, len);
    endtask

    task automatic send_fixed(logic [15:0] v, int len);
        logic [15:0] w [9];
        for (int i = 0; i < 9; i++) w[i] = v;
        send_notification(HDR0, HDR1, w, len);
    endtask

    initial
    begin
        logic [15:0] w [9];
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'd0;
        s_tlast       = 1'b0;
        bytes_sent    = 0;
        stimulus_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, zero, quarter turn angles.
        send_fixed(16'h7FFF, 20);
        send_fixed(16'h8000, 20);
        w = '{16'd0, 16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd0,
              16'h8000, 16'h7FFF, 16'h4000};
        send_notification(HDR0, HDR1, w, 20);
        // Short notification.
        send_fixed(16'h1234, 19);
        // Wrong first header byte, then wrong second byte.
        send_notification(8'hAA, HDR1, w, 20);
        send_notification(HDR0, 8'h9E, w, 20);
        // Long notification: extra bytes are dropped.
        send_fixed(16'h0101, 24);
        // Single byte notification.
        send_byte(8'hFF, 1'b1);

        while (bytes_sent < 1650) send_random_notification();
        s_tvalid      <= 1'b0;
        s_tlast       <= 1'b0;
        stimulus_done <= 1'b1;
    end

    // Sample side: random stall per sample, plus one long hold early on.
    initial
    begin
        int stall;
        m_tready  = 1'b0;
        long_hold = 1'b1;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        long_hold <= 1'b0;
        forever
        begin
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Watchdog on cycles without any transaction, and the end of the run.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || long_hold)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            if (stimulus_done && samples_pending == 0)
            begin
                repeat (600) @(posedge clk);
                if (error_count == 0)
                    $display("PASS");
                else
                    $display("FAIL");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

### files.f
rtl/imup_pkg.sv
rtl/imup_sine_rom.sv
rtl/imup_serial_mul.sv
rtl/imup_const_div.sv
rtl/imu_packet_to_quaternion.sv
tb/imu_sample_checker.sv
tb/tb_imu_packet_to_quaternion.sv
